FILE: design/atm_pkg.sv
// Package: shared types, codes and field widths for the allocation tracker.
package atm_pkg;

  // Payload widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIVE_W   = 5;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // One table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Table walk modes
  typedef enum logic [1:0] {
    SCAN_FIND  = 2'd0,
    SCAN_SHIFT = 2'd1,
    SCAN_MAX   = 2'd2
  } scan_mode_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_SHIFT_START,
    S_SHIFT,
    S_RELEASE,
    S_MAX_START,
    S_MAX
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                alloc_we;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                status_we;
    logic [STATUS_W-1:0] status_code;
    logic                scan_start;
    logic                scan_run;
    scan_mode_t          scan_mode;
    logic                capture;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_free;
    logic full;
    logic hit;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: design/atm_in_if.sv
// Interface: input channel carrying one alloc or release request per beat.
interface atm_in_if
  import atm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] block_address;
  logic [SIZE_W-1:0] block_size;

  modport source (output valid, output operation, output block_address,
                  output block_size, input ready);
  modport sink   (input valid, input operation, input block_address,
                  input block_size, output ready);
endinterface

FILE: design/atm_out_if.sv
// Interface: result channel carrying one status and largest-block report per beat.
interface atm_out_if
  import atm_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                max_found;
  logic [ADDR_W-1:0]   max_address;
  logic [SIZE_W-1:0]   max_size;
  logic [LIVE_W-1:0]   live_count;

  modport source (output valid, output status, output max_found, output max_address,
                  output max_size, output live_count, input ready);
  modport sink   (input valid, input status, input max_found, input max_address,
                  input max_size, input live_count, output ready);
endinterface

FILE: design/atm_dp.sv
// Datapath: entry table, live count, table walker and result register.
module atm_dp
  import atm_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  atm_in_if.sink   in_ch,
  atm_out_if.source out_ch
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // Entry memory, oldest entry at index 0
  entry_t mem [CAPACITY];

  // Latched request
  logic              op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SIZE_W-1:0] size_r;

  // Control registers
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          issue_r, issue_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pend_idx_r, pend_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Walk results and status
  logic [SIZE_W-1:0]   best_size_r, best_size_nxt;
  logic [ADDR_W-1:0]   best_addr_r, best_addr_nxt;
  logic                found_r, found_nxt;
  logic [STATUS_W-1:0] status_r;

  // Result register
  logic [STATUS_W-1:0] res_status_r;
  logic                res_found_r;
  logic [ADDR_W-1:0]   res_addr_r;
  logic [SIZE_W-1:0]   res_size_r;
  logic [LIVE_W-1:0]   res_live_r;

  // Memory ports
  entry_t        rd_r;
  logic          we;
  logic [CW-1:0] wa;
  entry_t        wd;
  logic [31:0]   cnt_ext;
  logic [CW-1:0] pos_plus;

  assign cnt_ext  = 32'(cnt_r);
  assign pos_plus = pos_r + ONE_C;

  // Latch request on the input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_ch.operation;
      addr_r <= in_ch.block_address;
      size_r <= in_ch.block_size;
    end
  end

  // Table walker: find and max walk newest to oldest, shift walks upward
  always_comb begin
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    best_size_nxt = best_size_r;
    best_addr_nxt = best_addr_r;
    found_nxt     = found_r;

    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + ONE_C;
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - ONE_C;
    end

    if (cmd.scan_start) begin
      pend_nxt = 1'b0;
      if (cmd.scan_mode == SCAN_SHIFT) begin
        idx_nxt   = pos_plus;
        issue_nxt = (pos_plus < cnt_r);
      end else begin
        idx_nxt   = cnt_r - ONE_C;
        issue_nxt = (cnt_r != '0);
      end
      if (cmd.scan_mode == SCAN_FIND) begin
        hit_nxt = 1'b0;
      end
      if (cmd.scan_mode == SCAN_MAX) begin
        best_size_nxt = '0;
        best_addr_nxt = '0;
        found_nxt     = 1'b0;
      end
    end else if (cmd.scan_run) begin
      // Issue side
      if (issue_r) begin
        pend_nxt     = 1'b1;
        pend_idx_nxt = idx_r;
        if (cmd.scan_mode == SCAN_SHIFT) begin
          idx_nxt   = idx_r + ONE_C;
          issue_nxt = ((idx_r + ONE_C) < cnt_r);
        end else begin
          idx_nxt   = idx_r - ONE_C;
          issue_nxt = (idx_r != '0);
        end
      end else begin
        pend_nxt = 1'b0;
      end
      // Compare side, on the entry read last cycle
      if (pend_r) begin
        case (cmd.scan_mode)
          SCAN_FIND: begin
            if (rd_r.addr == addr_r) begin
              hit_nxt   = 1'b1;
              pos_nxt   = pend_idx_r;
              issue_nxt = 1'b0;
              pend_nxt  = 1'b0;
            end
          end
          SCAN_MAX: begin
            // strict compare: newest wins among equal sizes
            if (rd_r.size > best_size_r) begin
              best_size_nxt = rd_r.size;
              best_addr_nxt = rd_r.addr;
              found_nxt     = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Memory write select: append on alloc, move down by one on shift
  always_comb begin
    we = 1'b0;
    wa = cnt_r;
    wd = rd_r;
    if (cmd.alloc_we) begin
      we      = 1'b1;
      wa      = cnt_r;
      wd.addr = addr_r;
      wd.size = size_r;
    end else if (cmd.scan_run && cmd.scan_mode == SCAN_SHIFT && pend_r) begin
      we = 1'b1;
      wa = pend_idx_r - ONE_C;
      wd = rd_r;
    end
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa[AW-1:0]] <= wd;
    end
    rd_r <= mem[idx_r[AW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk payload
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pos_r       <= pos_nxt;
    best_size_r <= best_size_nxt;
    best_addr_r <= best_addr_nxt;
    found_r     <= found_nxt;
    if (cmd.status_we) begin
      status_r <= cmd.status_code;
    end
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status_r <= status_r;
      res_found_r  <= found_r;
      res_addr_r   <= best_addr_r;
      res_size_r   <= best_size_r;
      res_live_r   <= cnt_ext[LIVE_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = res_status_r;
  assign out_ch.max_found   = res_found_r;
  assign out_ch.max_address = res_addr_r;
  assign out_ch.max_size    = res_size_r;
  assign out_ch.live_count  = res_live_r;

  // Status to controller
  assign stat.is_free   = (op_r == OP_FREE);
  assign stat.full      = (cnt_r == CAP_C);
  assign stat.hit       = hit_r;
  assign stat.scan_done = !issue_r && !pend_r;
  assign stat.out_free  = !out_valid_r || out_ch.ready;

endmodule

FILE: design/atm_ctrl.sv
// Controller: sequences dispatch, address search, table compaction and max walk.
module atm_ctrl
  import atm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_nxt = stat.is_free ? S_FIND : S_MAX_START;
      end
      S_FIND: begin
        if (stat.hit) begin
          state_nxt = S_SHIFT_START;
        end else if (stat.scan_done) begin
          state_nxt = S_MAX_START;
        end
      end
      S_SHIFT_START: state_nxt = S_SHIFT;
      S_SHIFT: begin
        if (stat.scan_done) state_nxt = S_RELEASE;
      end
      S_RELEASE:     state_nxt = S_MAX_START;
      S_MAX_START:   state_nxt = S_MAX;
      S_MAX: begin
        if (stat.scan_done && stat.out_free) state_nxt = S_IDLE;
      end
      default:       state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready        = 1'b0;
    cmd.load        = 1'b0;
    cmd.alloc_we    = 1'b0;
    cmd.cnt_inc     = 1'b0;
    cmd.cnt_dec     = 1'b0;
    cmd.status_we   = 1'b0;
    cmd.status_code = ST_OK;
    cmd.scan_start  = 1'b0;
    cmd.scan_run    = 1'b0;
    cmd.scan_mode   = SCAN_MAX;
    cmd.capture     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DISPATCH: begin
        if (stat.is_free) begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SCAN_FIND;
        end else if (stat.full) begin
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_FULL;
        end else begin
          cmd.alloc_we    = 1'b1;
          cmd.cnt_inc     = 1'b1;
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_OK;
        end
      end
      S_FIND: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_FIND;
        if (!stat.hit && stat.scan_done) begin
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_NOT_FOUND;
        end
      end
      S_SHIFT_START: begin
        cmd.scan_start  = 1'b1;
        cmd.scan_mode   = SCAN_SHIFT;
        cmd.status_we   = 1'b1;
        cmd.status_code = ST_OK;
      end
      S_SHIFT: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_SHIFT;
      end
      S_RELEASE: begin
        cmd.cnt_dec = 1'b1;
      end
      S_MAX_START: begin
        cmd.scan_start = 1'b1;
        cmd.scan_mode  = SCAN_MAX;
      end
      S_MAX: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_MAX;
        cmd.capture   = stat.scan_done && stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/allocation_tracker_max_block.sv
// Usage: allocation tracker with largest-live-block report.
// Input channel in_ch: one beat per request, operation 0 records (block_address,
// block_size) as the newest entry, operation 1 releases the newest entry whose
// address matches. Result channel out_ch: one beat per request with status,
// largest live size and its address (newest wins on ties) and live entry count.
// Requests are handled one at a time. The entry table is a single-port-read
// memory walked one entry per cycle: an alloc runs the max walk between accept
// and result; a release runs an address search, on a hit a compaction of newer
// entries, then the max walk.
// The result sits in an output register, so the next request is taken while a
// finished result still waits; a stalled receiver holds the block only when
// a second result is ready before the first is taken.
// Reset (synchronous, active low) empties the table and drops any pending
// result; the table contents need no clearing, only the live count resets.
module allocation_tracker_max_block
  import atm_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  atm_in_if.sink    in_ch,
  atm_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  atm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  atm_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
